[sv/acss_pkg.sv]
`timescale 1ns / 1ps

package acss_pkg;

   // Fixed by the widths of the item fields.
   localparam int CHANNELS    = 8;
   localparam int CH_BITS     = 3;
   localparam int SAMPLE_BITS = 10;
   localparam int FUNC_BITS   = 2;

   // Function codes carried by an input item.
   localparam logic [FUNC_BITS-1:0] FUNC_START = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_DONE  = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_READ  = 2'd2;

   typedef struct packed {
      logic [FUNC_BITS-1:0]   func;
      logic [CHANNELS-1:0]    scan_mask;
      logic [SAMPLE_BITS-1:0] sample;
   } item_type;

   typedef struct packed {
      logic                   convert_request;
      logic [CH_BITS-1:0]     convert_channel;
      logic                   sample_found;
      logic [SAMPLE_BITS-1:0] sample_value;
      logic [CH_BITS-1:0]     sample_channel;
      logic                   data_ready;
      logic                   scan_idle;
   } result_type;

   // Index of the lowest set bit; zero when no bit is set.
   function automatic logic [CH_BITS-1:0] lowest_bit(input logic [CHANNELS-1:0] m);
      logic [CH_BITS-1:0] idx;
      idx = '0;
      for (int i = CHANNELS - 1; i >= 0; i--) begin
         if (m[i]) begin
            idx = CH_BITS'(i);
         end
      end
      return idx;
   endfunction

   // One-hot vector with only bit c set.
   function automatic logic [CHANNELS-1:0] bit_of(input logic [CH_BITS-1:0] c);
      return {{(CHANNELS-1){1'b0}}, 1'b1} << c;
   endfunction

endpackage

[sv/acss_input_reg.sv]
`timescale 1ns / 1ps

// Input stage: holds one accepted item until the scan core has processed it.
module acss_input_reg import acss_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [FUNC_BITS-1:0]   req_func,
   input  logic [CHANNELS-1:0]    req_scan_mask,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   output logic                   req_stall,
   input  logic                   advance,
   output logic                   stage_valid,
   output item_type               stage_item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     load;

   assign load      = !valid_ff || advance;
   assign req_stall = !load;
   assign valid_in  = load ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         item_ff <= '{func: req_func, scan_mask: req_scan_mask, sample: req_sample};
      end
   end

   assign stage_valid = valid_ff;
   assign stage_item  = item_ff;

endmodule

[sv/acss_scan_core.sv]
`timescale 1ns / 1ps

// Scan state and the combinational step logic for one item.
module acss_scan_core import acss_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  item_type   item,
   output result_type result
);

   logic                   idle_ff, idle_in;
   logic [CHANNELS-1:0]    pending_ff, pending_in;
   logic [CHANNELS-1:0]    ready_ff, ready_in;
   logic [SAMPLE_BITS-1:0] data_ff [CHANNELS];

   logic                   wr_en;
   logic [CH_BITS-1:0]     wr_ch;
   logic [CH_BITS-1:0]     rd_ch;
   logic [CHANNELS-1:0]    pend_left;

   // Stored samples are only read for channels whose ready bit is set, and a
   // ready bit is only set together with a write, so the data needs no clear.
   always_comb begin
      idle_in    = idle_ff;
      pending_in = pending_ff;
      ready_in   = ready_ff;
      wr_en      = 1'b0;
      wr_ch      = lowest_bit(pending_ff);
      rd_ch      = lowest_bit(ready_ff);
      pend_left  = pending_ff & ~bit_of(wr_ch);
      result     = '0;

      case (item.func)
         FUNC_START: begin
            if (idle_ff) begin
               pending_in = item.scan_mask;
               ready_in   = '0;
               if (item.scan_mask != '0) begin
                  idle_in                = 1'b0;
                  result.convert_request = 1'b1;
                  result.convert_channel = lowest_bit(item.scan_mask);
               end
            end
         end
         FUNC_DONE: begin
            if (!idle_ff) begin
               if (pending_ff != '0) begin
                  wr_en    = 1'b1;
                  ready_in = ready_ff | bit_of(wr_ch);
               end
               pending_in = pend_left;
               if (pend_left != '0) begin
                  result.convert_request = 1'b1;
                  result.convert_channel = lowest_bit(pend_left);
               end else begin
                  idle_in = 1'b1;
               end
            end
         end
         FUNC_READ: begin
            if (idle_ff && ready_ff != '0) begin
               ready_in              = ready_ff & ~bit_of(rd_ch);
               result.sample_found   = 1'b1;
               result.sample_value   = data_ff[rd_ch];
               result.sample_channel = rd_ch;
            end
         end
         default: begin
         end
      endcase

      result.data_ready = idle_in && (ready_in != '0);
      result.scan_idle  = idle_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff    <= 1'b1;
         pending_ff <= '0;
         ready_ff   <= '0;
      end else if (step_en) begin
         idle_ff    <= idle_in;
         pending_ff <= pending_in;
         ready_ff   <= ready_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && wr_en) begin
         data_ff[wr_ch] <= item.sample;
      end
   end

endmodule

[sv/adc_channel_scan_sequencer_unit.sv]
`timescale 1ns / 1ps

// Scan sequencer for one analog converter over eight channels.
// The req_ channel carries one item per handshake: a start-scan with a channel
// mask, a conversion-finished with its sample, or a read of buffered data.
// Every accepted item yields exactly one item on the rsp_ channel: a convert
// request with its channel, any sample returned by a read, and the idle and
// data-ready status after the step.
// An accepted item is registered in the input stage; the step then stores its
// result in the result register once that is empty or being drained, and rsp_
// presents it from there. Throughput: one item per cycle while not stalled;
// the step is a few 8-bit priority encoders and an eight-entry sample
// register file between the two registers.
// Reset (synchronous, active high) empties both stages, makes the block idle
// and clears the pending and ready masks.
// When the receiver stalls, the result is held; the input stage still takes
// one more item, and req_stall rises once both stages are full.
module adc_channel_scan_sequencer_unit import acss_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [FUNC_BITS-1:0]   req_func,
   input  logic [CHANNELS-1:0]    req_scan_mask,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_convert_request,
   output logic [CH_BITS-1:0]     rsp_convert_channel,
   output logic                   rsp_sample_found,
   output logic [SAMPLE_BITS-1:0] rsp_sample_value,
   output logic [CH_BITS-1:0]     rsp_sample_channel,
   output logic                   rsp_data_ready,
   output logic                   rsp_scan_idle
);

   logic       stage_valid;
   item_type   stage_item;
   logic       rsp_free;
   logic       step_en;
   result_type step_result;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   // The result register can take a new result when empty or being drained.
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign step_en  = stage_valid && rsp_free;

   acss_input_reg u_input_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_func      (req_func),
      .req_scan_mask (req_scan_mask),
      .req_sample    (req_sample),
      .req_stall     (req_stall),
      .advance       (step_en),
      .stage_valid   (stage_valid),
      .stage_item    (stage_item)
   );

   // The scan state advances only when the result of this step is stored.
   acss_scan_core u_scan_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (stage_item),
      .result  (step_result)
   );

   assign rsp_valid_in = rsp_free ? stage_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_convert_request = rsp_ff.convert_request;
   assign rsp_convert_channel = rsp_ff.convert_channel;
   assign rsp_sample_found    = rsp_ff.sample_found;
   assign rsp_sample_value    = rsp_ff.sample_value;
   assign rsp_sample_channel  = rsp_ff.sample_channel;
   assign rsp_data_ready      = rsp_ff.data_ready;
   assign rsp_scan_idle       = rsp_ff.scan_idle;

endmodule

[sv/acss_checker.sv]
`timescale 1ns / 1ps

module acss_checker import acss_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic [FUNC_BITS-1:0]   req_func,
   input logic [CHANNELS-1:0]    req_scan_mask,
   input logic [SAMPLE_BITS-1:0] req_sample,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic                   rsp_convert_request,
   input logic [CH_BITS-1:0]     rsp_convert_channel,
   input logic                   rsp_sample_found,
   input logic [SAMPLE_BITS-1:0] rsp_sample_value,
   input logic [CH_BITS-1:0]     rsp_sample_channel,
   input logic                   rsp_data_ready,
   input logic                   rsp_scan_idle
);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A conversion request always leaves a scan running.
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_convert_request |-> !rsp_scan_idle)
      else $error("convert request reported with scan idle");

   // Reads only return data while idle.
   a_read_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sample_found |-> rsp_scan_idle)
      else $error("sample returned during a scan");

   // Data ready is only reported when idle.
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data_ready |-> rsp_scan_idle)
      else $error("data ready reported during a scan");

endmodule

bind adc_channel_scan_sequencer_unit acss_checker u_acss_checker (.*);
